>>> sv/pse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_pkg
// shared types, constants and the byte-wise crc-32 step for the png stream
// encoder
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int DIM_W   = 14;
    localparam int RAW_W   = 30;
    localparam int LEN_W   = 32;
    localparam int STEP_MAX = 52;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic [7:0]  ZLIB_CMF  = 8'h78;
    localparam logic [7:0]  ZLIB_FLG  = 8'h01;

    localparam logic [7:0] PNG_SIG [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                          8'h0D, 8'h0A, 8'h1A, 8'h0A};
    localparam logic [31:0] TYPE_IHDR = 32'h49484452;
    localparam logic [31:0] TYPE_IDAT = 32'h49444154;
    localparam logic [31:0] TYPE_IEND = 32'h49454E44;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_t;

    typedef struct packed {
        logic             done;
        logic [RAW_W-1:0] raw;
        logic [LEN_W-1:0] idat_len;
    } len_res_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> sv/pse_pixel_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_pixel_queue
// front side: takes pixel transactions and holds them for the byte sequencer
// ----------------------------------------------------------------------------
module pse_pixel_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  pse_pkg::pix_t in_pix,
    output logic          q_valid,
    output pse_pkg::pix_t q_pix,
    input  logic          q_pop
);
    import pse_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    pix_t               mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;
    logic               push;
    logic               pop;

    assign in_stall = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_pix    = mem_reg[rd_ptr_reg];
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_pix;
        end
    end

endmodule

>>> sv/pse_len_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_len_calc
// raw stream size and idat length from the image size, with a reciprocal
// multiply and one correction step for the stored block count
// ----------------------------------------------------------------------------
module pse_len_calc #(
    parameter int BLOCK_LIMIT = 65535
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pse_pkg::DIM_W-1:0] width,
    input  logic [pse_pkg::DIM_W-1:0] height,
    output pse_pkg::len_res_t         res
);
    import pse_pkg::*;

    localparam int PROD_W = 2 * RAW_W + 1;
    localparam int QD_W   = RAW_W + 16;
    localparam logic [15:0]    BL  = 16'(BLOCK_LIMIT);
    localparam logic [RAW_W:0] REC = (RAW_W+1)'((64'd1 << RAW_W) / 64'(BLOCK_LIMIT));

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_MUL  = 3'd1;
    localparam logic [2:0] P_REC  = 3'd2;
    localparam logic [2:0] P_FIX  = 3'd3;
    localparam logic [2:0] P_SUM  = 3'd4;

    logic [2:0]        ph_reg;
    logic [15:0]       tw_reg;
    logic [DIM_W-1:0]  h_reg;
    logic [RAW_W-1:0]  raw_reg;
    logic [RAW_W-1:0]  x_reg;
    logic [RAW_W-1:0]  q_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              done_reg;
    logic [RAW_W-1:0]  raw_mul;
    logic [PROD_W-1:0] prod;
    logic [QD_W-1:0]   qd;
    logic [QD_W-1:0]   rem;
    logic              ge;

    always_comb
    begin
        raw_mul = RAW_W'(h_reg) * RAW_W'(tw_reg);
        prod    = PROD_W'(x_reg) * PROD_W'(REC);
        qd      = QD_W'(q_reg) * QD_W'(BL);
        rem     = QD_W'(x_reg) - qd;
        ge      = (rem >= QD_W'(BL));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= P_IDLE;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            ph_reg   <= P_MUL;
            done_reg <= 1'b0;
        end
        else
        begin
            unique case (ph_reg)
                P_IDLE:
                begin
                    ph_reg <= P_IDLE;
                end
                P_MUL:
                begin
                    ph_reg <= P_REC;
                end
                P_REC:
                begin
                    ph_reg <= P_FIX;
                end
                P_FIX:
                begin
                    ph_reg <= P_SUM;
                end
                P_SUM:
                begin
                    ph_reg   <= P_IDLE;
                    done_reg <= 1'b1;
                end
                default:
                begin
                    ph_reg <= P_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            tw_reg <= 16'(({2'b0, width} << 1) + {2'b0, width} + 16'd1);
            h_reg  <= height;
        end
        else if (ph_reg == P_MUL)
        begin
            raw_reg <= raw_mul;
            x_reg   <= raw_mul + RAW_W'(BLOCK_LIMIT - 1);
        end
        else if (ph_reg == P_REC)
        begin
            q_reg <= prod[2*RAW_W-1:RAW_W];
        end
        else if (ph_reg == P_FIX)
        begin
            q_reg <= q_reg + RAW_W'(ge);
        end
        else if (ph_reg == P_SUM)
        begin
            len_reg <= LEN_W'(raw_reg) + (LEN_W'(q_reg) << 2) + LEN_W'(q_reg) + LEN_W'(6);
        end
    end

    assign res.done     = done_reg;
    assign res.raw      = raw_reg;
    assign res.idat_len = len_reg;

endmodule

>>> sv/pse_byte_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_byte_seq
// back side: walks the file layout for each pixel, sending one byte a cycle
// while not stalled; keeps crc-32, adler-32 and the stored block counters
// ----------------------------------------------------------------------------
module pse_byte_seq #(
    parameter int BLOCK_LIMIT = 65535,
    parameter int DIM_MAX     = 8192
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  pse_pkg::pix_t             q_pix,
    output logic                      q_pop,
    input  logic [pse_pkg::DIM_W-1:0] image_width,
    input  logic [pse_pkg::DIM_W-1:0] image_height,
    output logic                      calc_start,
    output logic [pse_pkg::DIM_W-1:0] calc_width,
    output logic [pse_pkg::DIM_W-1:0] calc_height,
    input  pse_pkg::len_res_t         len_res,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                out_byte,
    output logic                      run_last,
    output logic                      image_last
);
    import pse_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HDR  = 3'd1;
    localparam logic [2:0] S_BHDR = 3'd2;
    localparam logic [2:0] S_DATA = 3'd3;
    localparam logic [2:0] S_TAIL = 3'd4;

    localparam logic [15:0] BL = 16'(BLOCK_LIMIT);

    logic [2:0]        state_reg, state_next;
    logic [5:0]        idx_reg, idx_next;
    logic [1:0]        didx_reg, didx_next;
    logic              hold_reg, hold_next;
    logic [5:0]        step_reg, step_next;
    logic              end_img_reg, end_img_next;
    logic              hdr_sent_reg, hdr_sent_next;
    logic [DIM_W-1:0]  col_reg, col_next;
    logic [DIM_W-1:0]  row_reg, row_next;
    logic [DIM_W-1:0]  lat_w_reg, lat_w_next;
    logic [DIM_W-1:0]  lat_h_reg, lat_h_next;
    logic [31:0]       crc_reg, crc_next;
    logic [15:0]       alo_reg, alo_next;
    logic [15:0]       ahi_reg, ahi_next;
    logic [15:0]       blk_reg, blk_next;
    logic [RAW_W-1:0]  raw_reg, raw_next;
    pix_t              pix_reg, pix_next;
    logic              ov_reg;
    logic [7:0]        ob_reg;
    logic              orl_reg;
    logic              oil_reg;

    logic [DIM_W-1:0]  eff_w;
    logic [DIM_W-1:0]  eff_h;
    logic [DIM_W-1:0]  w_use;
    logic [DIM_W-1:0]  h_use;
    logic              last_col;
    logic              blk_final;
    logic [15:0]       blk_cnt;
    logic [7:0]        cur_byte;
    logic              cur_avail;
    logic              cur_crc;
    logic              cur_restart;
    logic              cur_done;
    logic              cur_tail_end;
    logic              emit;
    logic              step_full;
    logic              start_job;
    logic [31:0]       crc_out;
    logic [31:0]       w32;
    logic [31:0]       h32;
    logic [31:0]       adler32;
    logic [16:0]       lo_sum;
    logic [15:0]       lo_new;
    logic [16:0]       hi_sum;
    logic [15:0]       hi_new;

    always_comb
    begin
        if (image_width == '0)
            eff_w = DIM_W'(1);
        else if (32'(image_width) > 32'(DIM_MAX))
            eff_w = DIM_W'(DIM_MAX);
        else
            eff_w = image_width;
        if (image_height == '0)
            eff_h = DIM_W'(1);
        else if (32'(image_height) > 32'(DIM_MAX))
            eff_h = DIM_W'(DIM_MAX);
        else
            eff_h = image_height;
    end

    assign w_use     = hdr_sent_reg ? lat_w_reg : eff_w;
    assign h_use     = hdr_sent_reg ? lat_h_reg : eff_h;
    assign last_col  = ({1'b0, col_reg} + 1'b1) == {1'b0, w_use};
    assign blk_final = raw_reg <= RAW_W'(BLOCK_LIMIT);
    assign blk_cnt   = blk_final ? raw_reg[15:0] : BL;
    assign crc_out   = ~crc_reg;
    assign w32       = 32'(lat_w_reg);
    assign h32       = 32'(lat_h_reg);
    assign adler32   = {ahi_reg, alo_reg};

    // byte at the current position of the layout
    always_comb
    begin
        cur_byte     = 8'h00;
        cur_avail    = 1'b0;
        cur_crc      = 1'b0;
        cur_restart  = 1'b0;
        cur_done     = 1'b0;
        cur_tail_end = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cur_avail = 1'b0;
            end
            S_HDR:
            begin
                cur_avail   = (idx_reg < 6'd33) || len_res.done;
                cur_crc     = ((idx_reg >= 6'd12) && (idx_reg <= 6'd28)) || (idx_reg >= 6'd37);
                cur_restart = (idx_reg == 6'd12) || (idx_reg == 6'd37);
                if (idx_reg < 6'd8)
                    cur_byte = PNG_SIG[idx_reg[2:0]];
                else
                begin
                    case (idx_reg)
                        6'd11: cur_byte = 8'd13;
                        6'd12: cur_byte = TYPE_IHDR[31:24];
                        6'd13: cur_byte = TYPE_IHDR[23:16];
                        6'd14: cur_byte = TYPE_IHDR[15:8];
                        6'd15: cur_byte = TYPE_IHDR[7:0];
                        6'd16: cur_byte = w32[31:24];
                        6'd17: cur_byte = w32[23:16];
                        6'd18: cur_byte = w32[15:8];
                        6'd19: cur_byte = w32[7:0];
                        6'd20: cur_byte = h32[31:24];
                        6'd21: cur_byte = h32[23:16];
                        6'd22: cur_byte = h32[15:8];
                        6'd23: cur_byte = h32[7:0];
                        6'd24: cur_byte = 8'd8;
                        6'd25: cur_byte = 8'd2;
                        6'd29: cur_byte = crc_out[31:24];
                        6'd30: cur_byte = crc_out[23:16];
                        6'd31: cur_byte = crc_out[15:8];
                        6'd32: cur_byte = crc_out[7:0];
                        6'd33: cur_byte = len_res.idat_len[31:24];
                        6'd34: cur_byte = len_res.idat_len[23:16];
                        6'd35: cur_byte = len_res.idat_len[15:8];
                        6'd36: cur_byte = len_res.idat_len[7:0];
                        6'd37: cur_byte = TYPE_IDAT[31:24];
                        6'd38: cur_byte = TYPE_IDAT[23:16];
                        6'd39: cur_byte = TYPE_IDAT[15:8];
                        6'd40: cur_byte = TYPE_IDAT[7:0];
                        6'd41: cur_byte = ZLIB_CMF;
                        6'd42: cur_byte = ZLIB_FLG;
                        default: cur_byte = 8'h00;
                    endcase
                end
            end
            S_BHDR:
            begin
                cur_avail = 1'b1;
                cur_crc   = 1'b1;
                case (idx_reg)
                    6'd1: cur_byte = blk_cnt[7:0];
                    6'd2: cur_byte = blk_cnt[15:8];
                    6'd3: cur_byte = ~blk_cnt[7:0];
                    6'd4: cur_byte = ~blk_cnt[15:8];
                    default: cur_byte = 8'h00;
                endcase
            end
            S_DATA:
            begin
                cur_avail = 1'b1;
                cur_crc   = 1'b1;
                if (blk_reg == '0)
                    cur_byte = {7'd0, blk_final};
                else
                begin
                    unique case (didx_reg)
                        2'd0: cur_byte = 8'h00;
                        2'd1: cur_byte = pix_reg.red;
                        2'd2: cur_byte = pix_reg.green;
                        2'd3: cur_byte = pix_reg.blue;
                    endcase
                    cur_done = (didx_reg == 2'd3) && !end_img_reg;
                end
            end
            S_TAIL:
            begin
                cur_avail    = 1'b1;
                cur_crc      = (idx_reg <= 6'd3) || ((idx_reg >= 6'd12) && (idx_reg <= 6'd15));
                cur_restart  = (idx_reg == 6'd12);
                cur_tail_end = (idx_reg == 6'd19);
                case (idx_reg)
                    6'd0:  cur_byte = adler32[31:24];
                    6'd1:  cur_byte = adler32[23:16];
                    6'd2:  cur_byte = adler32[15:8];
                    6'd3:  cur_byte = adler32[7:0];
                    6'd4:  cur_byte = crc_out[31:24];
                    6'd5:  cur_byte = crc_out[23:16];
                    6'd6:  cur_byte = crc_out[15:8];
                    6'd7:  cur_byte = crc_out[7:0];
                    6'd12: cur_byte = TYPE_IEND[31:24];
                    6'd13: cur_byte = TYPE_IEND[23:16];
                    6'd14: cur_byte = TYPE_IEND[15:8];
                    6'd15: cur_byte = TYPE_IEND[7:0];
                    6'd16: cur_byte = crc_out[31:24];
                    6'd17: cur_byte = crc_out[23:16];
                    6'd18: cur_byte = crc_out[15:8];
                    6'd19: cur_byte = crc_out[7:0];
                    default: cur_byte = 8'h00;
                endcase
            end
            default:
            begin
                cur_avail = 1'b0;
            end
        endcase
    end

    assign emit      = cur_avail && !hold_reg && (!ov_reg || !out_stall);
    assign step_full = (step_reg == 6'(STEP_MAX - 1));
    assign start_job = q_valid && !hold_reg && ((state_reg == S_IDLE) || (emit && cur_done));
    assign q_pop     = start_job || (hold_reg && q_valid);

    assign lo_sum = {1'b0, alo_reg} + {9'd0, cur_byte};
    assign lo_new = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
    assign hi_sum = {1'b0, ahi_reg} + {1'b0, lo_new};
    assign hi_new = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        didx_next     = didx_reg;
        hold_next     = hold_reg;
        step_next     = step_reg;
        end_img_next  = end_img_reg;
        hdr_sent_next = hdr_sent_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        lat_w_next    = lat_w_reg;
        lat_h_next    = lat_h_reg;
        crc_next      = crc_reg;
        alo_next      = alo_reg;
        ahi_next      = ahi_reg;
        blk_next      = blk_reg;
        raw_next      = raw_reg;
        pix_next      = pix_reg;
        calc_start    = 1'b0;

        if (hold_reg && q_valid)
        begin
            // pixel taken only to let the surplus continue
            hold_next = 1'b0;
            step_next = '0;
        end

        if (emit)
        begin
            if (cur_crc)
                crc_next = crc_byte(cur_restart ? CRC_INIT : crc_reg, cur_byte);
            if (cur_done || cur_tail_end)
                step_next = '0;
            else if (step_full)
            begin
                step_next = '0;
                hold_next = 1'b1;
            end
            else
                step_next = step_reg + 1'b1;

            unique case (state_reg)
                S_HDR:
                begin
                    if (idx_reg == 6'd42)
                    begin
                        state_next = S_DATA;
                        didx_next  = 2'd0;
                        raw_next   = len_res.raw;
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
                S_BHDR:
                begin
                    if (idx_reg == 6'd4)
                        state_next = S_DATA;
                    else
                        idx_next = idx_reg + 1'b1;
                end
                S_DATA:
                begin
                    if (blk_reg == '0)
                    begin
                        state_next = S_BHDR;
                        idx_next   = 6'd1;
                        blk_next   = blk_cnt;
                    end
                    else
                    begin
                        alo_next = lo_new;
                        ahi_next = hi_new;
                        blk_next = blk_reg - 1'b1;
                        raw_next = raw_reg - 1'b1;
                        if (didx_reg == 2'd3)
                        begin
                            if (end_img_reg)
                            begin
                                state_next = S_TAIL;
                                idx_next   = '0;
                            end
                            else
                                state_next = S_IDLE;
                        end
                        else
                            didx_next = didx_reg + 1'b1;
                    end
                end
                S_TAIL:
                begin
                    if (idx_reg == 6'd19)
                    begin
                        state_next    = S_IDLE;
                        hdr_sent_next = 1'b0;
                        crc_next      = CRC_INIT;
                        alo_next      = 16'd1;
                        ahi_next      = '0;
                        blk_next      = '0;
                        raw_next      = '0;
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end

        if (start_job)
        begin
            pix_next     = q_pix;
            end_img_next = last_col && (({1'b0, row_reg} + 1'b1) == {1'b0, h_use});
            col_next     = last_col ? '0 : col_reg + 1'b1;
            if (last_col)
                row_next = end_img_next ? '0 : row_reg + 1'b1;
            if (!hdr_sent_reg)
            begin
                state_next    = S_HDR;
                idx_next      = '0;
                lat_w_next    = eff_w;
                lat_h_next    = eff_h;
                hdr_sent_next = 1'b1;
                calc_start    = 1'b1;
            end
            else
            begin
                state_next = S_DATA;
                didx_next  = (col_reg == '0) ? 2'd0 : 2'd1;
            end
        end
    end

    assign calc_width  = eff_w;
    assign calc_height = eff_h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            didx_reg     <= '0;
            hold_reg     <= 1'b0;
            step_reg     <= '0;
            end_img_reg  <= 1'b0;
            hdr_sent_reg <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            lat_w_reg    <= DIM_W'(1);
            lat_h_reg    <= DIM_W'(1);
            crc_reg      <= CRC_INIT;
            alo_reg      <= 16'd1;
            ahi_reg      <= '0;
            blk_reg      <= '0;
            raw_reg      <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            didx_reg     <= didx_next;
            hold_reg     <= hold_next;
            step_reg     <= step_next;
            end_img_reg  <= end_img_next;
            hdr_sent_reg <= hdr_sent_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            lat_w_reg    <= lat_w_next;
            lat_h_reg    <= lat_h_next;
            crc_reg      <= crc_next;
            alo_reg      <= alo_next;
            ahi_reg      <= ahi_next;
            blk_reg      <= blk_next;
            raw_reg      <= raw_next;
            if (emit)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
        if (emit)
        begin
            ob_reg  <= cur_byte;
            orl_reg <= cur_done || cur_tail_end || step_full;
            oil_reg <= cur_tail_end;
        end
    end

    assign out_valid  = ov_reg;
    assign out_byte   = ob_reg;
    assign run_last   = orl_reg;
    assign image_last = oil_reg;

endmodule

>>> sv/png_stored_stream_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_stored_stream_encoder_core
// rgb pixels in, bytes of a png file with stored deflate blocks out
// ----------------------------------------------------------------------------
//  channel  signals                              moves
//  in       in_valid/in_stall, red green blue    one pixel per transaction
//  out      out_valid/out_stall, out_byte,       one file byte per transaction
//           run_last, image_last
//  cfg      cfg_valid/cfg_ready, cfg_index,      image_width (0), image_height (1)
//           cfg_data
//
//  one byte leaves per cycle while out_stall is low, so a pixel gives 3 or 4
//  bytes plus 5 for each stored block header
//  the first pixel of an image adds 43 bytes for signature, ihdr and idat start
//  the last pixel adds 20 bytes of adler, crc and iend
//  bytes past 52 for one pixel wait for the next pixel, which is dropped
//  a four-entry pixel queue lets input and output stall on their own
//  reset needs no clearing pass
// ----------------------------------------------------------------------------
module png_stored_stream_encoder_core #(
    parameter int BLOCK_LIMIT = 65535,
    parameter int DIM_MAX     = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        image_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [13:0] cfg_data
);
    import pse_pkg::*;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    pix_t             in_pix;
    logic             q_valid;
    pix_t             q_pix;
    logic             q_pop;
    logic             calc_start;
    logic [DIM_W-1:0] calc_width;
    logic [DIM_W-1:0] calc_height;
    len_res_t         len_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    assign in_pix.red   = red;
    assign in_pix.green = green;
    assign in_pix.blue  = blue;

    pse_pixel_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_pix   (in_pix),
        .q_valid  (q_valid),
        .q_pix    (q_pix),
        .q_pop    (q_pop)
    );

    pse_len_calc #(
        .BLOCK_LIMIT (BLOCK_LIMIT)
    ) u_len (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (calc_start),
        .width  (calc_width),
        .height (calc_height),
        .res    (len_res)
    );

    pse_byte_seq #(
        .BLOCK_LIMIT (BLOCK_LIMIT),
        .DIM_MAX     (DIM_MAX)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pix        (q_pix),
        .q_pop        (q_pop),
        .image_width  (width_reg),
        .image_height (height_reg),
        .calc_start   (calc_start),
        .calc_width   (calc_width),
        .calc_height  (calc_height),
        .len_res      (len_res),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .image_last   (image_last)
    );

    a_image_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && image_last |-> run_last)
        else $error("image_last without run_last");

    a_stalled_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(run_last)
            && $stable(image_last))
        else $error("stalled output transaction changed");

    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        calc_start |-> q_valid)
        else $error("header started without a pixel");

endmodule

>>> tb/png_stored_stream_encoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_stored_stream_encoder_core_tb
// self-checking bench: pixels go in, every byte of the png file is predicted
// by a scoreboard that tracks chunk crc, adler sums and stored block framing,
// and is compared field by field; random stalls and gaps on both channels
// ----------------------------------------------------------------------------
module png_stored_stream_encoder_core_tb;
    import pse_pkg::*;

    typedef struct {
        logic [7:0] ob;
        logic       run_end;
        logic       file_end;
    } file_byte_t;

    class png_byte_scoreboard;
        int unsigned cfg_width;
        int unsigned cfg_height;
        int unsigned lat_w;
        int unsigned lat_h;
        logic [31:0] crc;
        int unsigned ad_lo;
        int unsigned ad_hi;
        int unsigned col;
        int unsigned row;
        int unsigned blk_left;
        int unsigned raw_left;
        bit          in_image;
        logic [8:0]  built [$];
        logic [8:0]  overflow [$];
        file_byte_t  expected_bytes [$];
        int          errors;

        function new();
            cfg_width = 1;
            cfg_height = 1;
            crc = 32'hFFFFFFFF;
            ad_lo = 1;
            errors = 0;
        endfunction

        function void set_register(logic idx, logic [13:0] val);
            if (idx == 1'b0) cfg_width = val;
            else cfg_height = val;
        endfunction

        function int unsigned clamp_dim(int unsigned v);
            if (v == 0) return 1;
            if (v > 8192) return 8192;
            return v;
        endfunction

        function void emit(logic [7:0] b, bit with_crc);
            logic [31:0] c;
            built.insert(built.size(), {1'b0, b});
            if (with_crc)
            begin
                c = crc ^ {24'd0, b};
                for (int i = 0; i < 8; i++)
                    c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
                crc = c;
            end
        endfunction

        function void emit_word(logic [31:0] v, bit with_crc);
            for (int i = 3; i >= 0; i--)
                emit(v[i*8 +: 8], with_crc);
        endfunction

        function void open_chunk(logic [31:0] len, logic [31:0] kind);
            emit_word(len, 1'b0);
            crc = 32'hFFFFFFFF;
            emit_word(kind, 1'b1);
        endfunction

        function void start_image();
            int unsigned raw;
            int unsigned blocks;
            lat_w = clamp_dim(cfg_width);
            lat_h = clamp_dim(cfg_height);
            raw = lat_h * (3 * lat_w + 1);
            blocks = (raw + 65534) / 65535;
            for (int i = 0; i < 8; i++) emit(PNG_SIG[i], 1'b0);
            open_chunk(13, TYPE_IHDR);
            emit_word(lat_w, 1'b1);
            emit_word(lat_h, 1'b1);
            emit(8'd8, 1'b1);
            emit(8'd2, 1'b1);
            emit(8'd0, 1'b1);
            emit(8'd0, 1'b1);
            emit(8'd0, 1'b1);
            emit_word(~crc, 1'b0);
            open_chunk(2 + 5 * blocks + raw + 4, TYPE_IDAT);
            emit(ZLIB_CMF, 1'b1);
            emit(ZLIB_FLG, 1'b1);
            raw_left = raw;
            blk_left = 0;
            ad_lo = 1;
            ad_hi = 0;
            col = 0;
            row = 0;
            in_image = 1;
        endfunction

        function void raw_byte(logic [7:0] b);
            int unsigned cnt;
            logic [15:0] ncnt;
            if (blk_left == 0)
            begin
                cnt = (raw_left > 65535) ? 65535 : raw_left;
                ncnt = ~cnt[15:0];
                emit((cnt == raw_left) ? 8'd1 : 8'd0, 1'b1);
                emit(cnt[7:0], 1'b1);
                emit(cnt[15:8], 1'b1);
                emit(ncnt[7:0], 1'b1);
                emit(ncnt[15:8], 1'b1);
                blk_left = cnt;
            end
            emit(b, 1'b1);
            ad_lo += b;
            if (ad_lo >= 65521) ad_lo -= 65521;
            ad_hi += ad_lo;
            if (ad_hi >= 65521) ad_hi -= 65521;
            if (blk_left != 0) blk_left--;
            if (raw_left != 0) raw_left--;
        endfunction

        function void finish_image();
            emit_word({ad_hi[15:0], ad_lo[15:0]}, 1'b1);
            emit_word(~crc, 1'b0);
            open_chunk(0, TYPE_IEND);
            emit_word(~crc, 1'b0);
            built[built.size()-1][8] = 1'b1;
            in_image = 0;
            crc = 32'hFFFFFFFF;
        endfunction

        function void push_run(ref logic [8:0] src [$]);
            int n;
            file_byte_t e;
            n = (src.size() > STEP_MAX) ? STEP_MAX : src.size();
            for (int k = 0; k < n; k++)
            begin
                e.ob = src[0][7:0];
                e.file_end = src[0][8];
                e.run_end = (k == n - 1);
                expected_bytes.insert(expected_bytes.size(), e);
                void'(src.pop_front());
            end
        endfunction

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            if (overflow.size() != 0)
            begin
                push_run(overflow);
                return;
            end
            built.delete();
            if (!in_image) start_image();
            if (col == 0) raw_byte(8'd0);
            raw_byte(r);
            raw_byte(g);
            raw_byte(b);
            col++;
            if (col >= lat_w)
            begin
                col = 0;
                row++;
                if (row >= lat_h) finish_image();
            end
            push_run(built);
            overflow = built;
            built.delete();
        endfunction

        function void check_byte(logic [7:0] ob, logic rl, logic il);
            file_byte_t e;
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected output transaction out_byte=%h", ob);
                errors++;
                return;
            end
            e = expected_bytes.pop_front();
            if (ob !== e.ob)
            begin
                $error("out_byte expected %h actual %h", e.ob, ob);
                errors++;
            end
            if (rl !== e.run_end)
            begin
                $error("run_last expected %b actual %b", e.run_end, rl);
                errors++;
            end
            if (il !== e.file_end)
            begin
                $error("image_last expected %b actual %b", e.file_end, il);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        image_last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [13:0] cfg_data;

    png_byte_scoreboard sb;
    bit quiet;

    png_stored_stream_encoder_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .image_last (image_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int p;
        if (quiet) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    int stall_left;

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_left <= pick_gap();
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_byte(out_byte, run_last, image_last);
    end

    task automatic drain();
        while (sb.expected_bytes.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        red <= r;
        green <= g;
        blue <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_pixel(r, g, b);
        @(negedge clk);
    endtask

    task automatic write_register(logic idx, logic [13:0] val);
        in_valid <= 1'b0;
        drain();
        repeat (25) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_register(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // whole image of random pixels, then flush any carried-over bytes
    task automatic run_image(logic [13:0] w, logic [13:0] h, bit pause_once);
        int unsigned total;
        int unsigned stop_at;
        write_register(1'b0, w);
        write_register(1'b1, h);
        total = sb.clamp_dim(w) * sb.clamp_dim(h);
        stop_at = pause_once ? $urandom_range(0, total - 1) : total;
        for (int unsigned i = 0; i < total; i++)
        begin
            if (i == stop_at)
            begin
                in_valid <= 1'b0;
                drain();
            end
            send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        end
        while (sb.overflow.size() != 0)
            send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int sent;
        logic [13:0] w;
        logic [13:0] h;
        sb = new();
        quiet = 0;
        stall_left = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        red = 8'd0;
        green = 8'd0;
        blue = 8'd0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 14'd0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // one-pixel image from zero registers, then the pixel that gets dropped
        write_register(1'b0, 14'd0);
        write_register(1'b1, 14'd0);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);

        write_register(1'b0, 14'd2);
        write_register(1'b1, 14'd2);
        send_pixel(8'hFF, 8'h00, 8'hFF);
        send_pixel(8'h55, 8'hAA, 8'h55);
        send_pixel(8'hAA, 8'h55, 8'hAA);
        send_pixel(8'h00, 8'hFF, 8'h00);

        write_register(1'b0, 14'd3);
        write_register(1'b1, 14'd1);
        send_pixel(8'h01, 8'h80, 8'h7F);
        send_pixel(8'hFE, 8'h01, 8'h02);
        send_pixel(8'h10, 8'h20, 8'h40);

        sent = 0;
        while (sent < 130)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            w = 14'($urandom_range(0, 7));
            h = 14'($urandom_range(0, 4));
            run_image(w, h, $urandom_range(0, 3) == 0);
            sent += int'(sb.clamp_dim(w) * sb.clamp_dim(h));
        end

        in_valid <= 1'b0;
        drain();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.expected_bytes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
